[hdl/sjfs_pkg.sv]
package sjfs_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  process_id;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  running_id;
    logic        cpu_idle;
    logic        first_run;
    logic        finished;
    logic        table_full;
    logic [31:0] time_now;
  } out_item_t;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic             force_en;
    logic [IDX_W-1:0] force_idx;
    logic             best_valid;
    logic [IDX_W-1:0] best_idx;
    logic [15:0]      best_rem;
    logic [7:0]       best_pid;
    logic             best_started;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } probe_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_ARRIVE,
    UPD_TICK
  } upd_op_e;

  typedef struct packed {
    upd_op_e          op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       pid;
    logic [15:0]      burst;
  } upd_t;

endpackage

[hdl/sjfs_cell.sv]
module sjfs_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [sjfs_pkg::IDX_W-1:0] cell_idx_i,
  input  sjfs_pkg::probe_t         link_i,
  output sjfs_pkg::probe_t         link_o,
  input  sjfs_pkg::upd_t           upd_i,
  output logic                     valid_o
);

  logic        valid_q, valid_d;
  logic        started_q, started_d;
  logic [7:0]  pid_q, pid_d;
  logic [15:0] rem_q, rem_d;
  sjfs_pkg::probe_t link_q, link_d;
  logic        own_better;
  logic        take;
  logic        hit;

  always_comb begin
    own_better = !link_i.best_valid || (rem_q < link_i.best_rem) ||
                 ((rem_q == link_i.best_rem) && (pid_q > link_i.best_pid));
    if (link_i.force_en) begin
      take = valid_q && (cell_idx_i == link_i.force_idx);
    end else begin
      take = valid_q && own_better;
    end
    link_d = link_i;
    if (take) begin
      link_d.best_valid   = 1'b1;
      link_d.best_idx     = cell_idx_i;
      link_d.best_rem     = rem_q;
      link_d.best_pid     = pid_q;
      link_d.best_started = started_q;
    end
    if (!link_i.free_found && !valid_q) begin
      link_d.free_found = 1'b1;
      link_d.free_idx   = cell_idx_i;
    end
  end

  always_comb begin
    hit       = (upd_i.idx == cell_idx_i);
    valid_d   = valid_q;
    started_d = started_q;
    pid_d     = pid_q;
    rem_d     = rem_q;
    case (upd_i.op)
      sjfs_pkg::UPD_ARRIVE: begin
        if (hit) begin
          valid_d   = 1'b1;
          started_d = 1'b0;
          pid_d     = upd_i.pid;
          rem_d     = upd_i.burst;
        end
      end
      sjfs_pkg::UPD_TICK: begin
        if (hit) begin
          started_d = 1'b1;
          rem_d     = rem_q - 16'd1;
          if (rem_q == 16'd1) begin
            valid_d   = 1'b0;
            started_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      started_q <= 1'b0;
      link_q    <= '0;
    end else begin
      valid_q   <= valid_d;
      started_q <= started_d;
      link_q    <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q <= pid_d;
    rem_q <= rem_d;
  end

  assign link_o  = link_q;
  assign valid_o = valid_q;

endmodule

[hdl/shortest_job_first_scheduler.sv]
// Shortest-job scheduler over a row of NUM_SLOTS process slots. Every item,
// arrive or tick, sends a search token down the row of slot cells, one cell
// per cycle, and its result is registered once the token has walked the row.
// The next item is taken in the cycle after the result is registered, so the
// block takes no new item while one is still in flight; a new result waits
// in S_DONE while a stalled earlier result still holds the output register.
// The result waits in an output register while the next item is accepted.
// The mode register is written through its own channel, which is always
// ready, and must only be written while the block is idle.
module shortest_job_first_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sjfs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sjfs_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic                         mode_q;
  logic                         run_valid_q;
  logic [sjfs_pkg::IDX_W-1:0]   run_slot_q;
  logic [31:0]                  time_q;
  sjfs_pkg::in_item_t           item_q;
  sjfs_pkg::probe_t             probe_q, probe_d;
  sjfs_pkg::probe_t             res_q;
  sjfs_pkg::upd_t               upd_q, upd_d;
  logic                         out_valid_q;
  sjfs_pkg::out_item_t          out_q, out_d;
  sjfs_pkg::probe_t             links [sjfs_pkg::NUM_SLOTS+1];
  logic [sjfs_pkg::NUM_SLOTS-1:0] slot_valid;
  logic                         in_acc;
  logic                         out_free;
  logic                         force_en;
  logic                         done_go;

  assign links[0]    = probe_q;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign done_go     = (state_q == S_DONE) && out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign force_en    = !mode_q && run_valid_q && slot_valid[run_slot_q];

  for (genvar i = 0; i < sjfs_pkg::NUM_SLOTS; i++) begin : g_cell
    sjfs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (sjfs_pkg::IDX_W'(i)),
      .link_i     (links[i]),
      .link_o     (links[i+1]),
      .upd_i      (upd_q),
      .valid_o    (slot_valid[i])
    );
  end

  always_comb begin
    probe_d = '0;
    if (in_acc) begin
      probe_d.active    = 1'b1;
      probe_d.force_en  = (in_item_i.cmd == sjfs_pkg::CMD_TICK) && force_en;
      probe_d.force_idx = run_slot_q;
    end
  end

  always_comb begin
    out_d       = '0;
    upd_d       = '0;
    upd_d.op    = sjfs_pkg::UPD_NONE;
    upd_d.pid   = item_q.process_id;
    upd_d.burst = item_q.burst_length;
    if (item_q.cmd == sjfs_pkg::CMD_ARRIVE) begin
      out_d.time_now = time_q;
      if (item_q.burst_length != 16'd0) begin
        if (res_q.free_found) begin
          upd_d.op  = sjfs_pkg::UPD_ARRIVE;
          upd_d.idx = res_q.free_idx;
        end else begin
          out_d.table_full = 1'b1;
        end
      end
    end else begin
      out_d.time_now = time_q + 32'd1;
      if (!res_q.best_valid) begin
        out_d.cpu_idle = 1'b1;
      end else begin
        out_d.running_id = res_q.best_pid;
        out_d.first_run  = !res_q.best_started;
        out_d.finished   = (res_q.best_rem == 16'd1);
        upd_d.op         = sjfs_pkg::UPD_TICK;
        upd_d.idx        = res_q.best_idx;
      end
    end
    if (!done_go) begin
      upd_d.op = sjfs_pkg::UPD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b1;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      time_q      <= '0;
      item_q      <= '0;
      probe_q     <= '0;
      res_q       <= '0;
      upd_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      probe_q <= probe_d;
      upd_q   <= upd_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            item_q  <= in_item_i;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (links[sjfs_pkg::NUM_SLOTS].active) begin
            res_q   <= links[sjfs_pkg::NUM_SLOTS];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (item_q.cmd == sjfs_pkg::CMD_TICK) begin
              time_q <= time_q + 32'd1;
              if (!res_q.best_valid) begin
                run_valid_q <= 1'b0;
              end else begin
                run_valid_q <= (res_q.best_rem != 16'd1);
                run_slot_q  <= res_q.best_idx;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/tb_shortest_job_first_scheduler.sv]
module tb_shortest_job_first_scheduler;

  localparam int unsigned SETTLE_CYCLES = 2 * (sjfs_pkg::NUM_SLOTS + 3);
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int unsigned EXP_DEPTH = 64;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sjfs_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sjfs_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  bit         slot_busy [sjfs_pkg::NUM_SLOTS];
  logic [7:0] slot_owner [sjfs_pkg::NUM_SLOTS];
  logic [15:0] slot_left [sjfs_pkg::NUM_SLOTS];
  bit         slot_begun [sjfs_pkg::NUM_SLOTS];
  int         cur_slot = -1;
  logic [31:0] clock_units = '0;
  bit         srtf_mode = 1'b1;

  sjfs_pkg::out_item_t expected_items [EXP_DEPTH];
  int unsigned         n_expected_in = 0;
  int unsigned         n_expected_out = 0;
  sjfs_pkg::out_item_t oldest_report;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  logic        hold_receiver = 1'b0;

  int unsigned errors = 0;
  int unsigned n_arrivals = 0;
  int unsigned n_ticks = 0;
  int unsigned n_finished = 0;
  int unsigned n_rejected = 0;
  int unsigned n_idle = 0;

  shortest_job_first_scheduler i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic sjfs_pkg::out_item_t schedule_item(input sjfs_pkg::in_item_t item);
    sjfs_pkg::out_item_t res;
    int                  sel;
    int                  free_idx;
    res = '0;
    if (item.cmd == sjfs_pkg::CMD_ARRIVE) begin
      if (item.burst_length != 16'd0) begin
        free_idx = -1;
        for (int i = 0; i < sjfs_pkg::NUM_SLOTS; i++) begin
          if (!slot_busy[i] && free_idx < 0) free_idx = i;
        end
        if (free_idx < 0) begin
          res.table_full = 1'b1;
        end else begin
          slot_busy[free_idx]  = 1'b1;
          slot_owner[free_idx] = item.process_id;
          slot_left[free_idx]  = item.burst_length;
          slot_begun[free_idx] = 1'b0;
        end
      end
      res.time_now = clock_units;
      return res;
    end
    if (!srtf_mode && cur_slot >= 0 && slot_busy[cur_slot]) begin
      sel = cur_slot;
    end else begin
      sel = -1;
      for (int i = 0; i < sjfs_pkg::NUM_SLOTS; i++) begin
        if (slot_busy[i] && (sel < 0 || slot_left[i] < slot_left[sel] ||
            (slot_left[i] == slot_left[sel] && slot_owner[i] > slot_owner[sel])))
          sel = i;
      end
    end
    if (sel < 0) begin
      cur_slot     = -1;
      res.cpu_idle = 1'b1;
    end else begin
      res.running_id  = slot_owner[sel];
      res.first_run   = !slot_begun[sel];
      slot_begun[sel] = 1'b1;
      slot_left[sel]  = slot_left[sel] - 16'd1;
      if (slot_left[sel] == 16'd0) begin
        res.finished    = 1'b1;
        slot_busy[sel]  = 1'b0;
        slot_begun[sel] = 1'b0;
        cur_slot        = -1;
      end else begin
        cur_slot = sel;
      end
    end
    clock_units  = clock_units + 32'd1;
    res.time_now = clock_units;
    return res;
  endfunction

  function automatic sjfs_pkg::in_item_t make_arrival(input logic [7:0] pid,
                                                      input logic [15:0] burst);
    sjfs_pkg::in_item_t item;
    item.cmd          = sjfs_pkg::CMD_ARRIVE;
    item.process_id   = pid;
    item.burst_length = burst;
    return item;
  endfunction

  function automatic sjfs_pkg::in_item_t make_tick();
    sjfs_pkg::in_item_t item;
    item.cmd          = sjfs_pkg::CMD_TICK;
    item.process_id   = 8'($urandom);
    item.burst_length = 16'($urandom);
    return item;
  endfunction

  function automatic sjfs_pkg::in_item_t random_item();
    sjfs_pkg::in_item_t item;
    item.cmd = ($urandom_range(99) < 25) ? sjfs_pkg::CMD_ARRIVE : sjfs_pkg::CMD_TICK;
    item.process_id = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    case ($urandom_range(19))
      0: begin
        item.burst_length = 16'd0;
      end
      1: begin
        item.burst_length = 16'($urandom_range(5, 30));
      end
      default: begin
        item.burst_length = 16'($urandom_range(1, 4));
      end
    endcase
    return item;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (n_expected_in == n_expected_out) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
        errors++;
      end else begin
        oldest_report = expected_items[6'(n_expected_out)];
        n_expected_out++;
        compare_field("running_id", 32'(oldest_report.running_id),
                      32'(out_item.running_id));
        compare_field("cpu_idle", 32'(oldest_report.cpu_idle), 32'(out_item.cpu_idle));
        compare_field("first_run", 32'(oldest_report.first_run), 32'(out_item.first_run));
        compare_field("finished", 32'(oldest_report.finished), 32'(out_item.finished));
        compare_field("table_full", 32'(oldest_report.table_full),
                      32'(out_item.table_full));
        compare_field("time_now", oldest_report.time_now, out_item.time_now);
        if (out_item.finished) n_finished++;
        if (out_item.table_full) n_rejected++;
        if (out_item.cpu_idle) n_idle++;
      end
    end
    out_stall <= hold_receiver ||
                 (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // The receiver holds off for a fixed stretch once a hold is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_receiver <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_receiver <= 1'b0;
        hold_request  <= 1'b0;
      end
    end
  end

  task automatic offer_item(input sjfs_pkg::in_item_t item);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    expected_items[6'(n_expected_in)] = schedule_item(item);
    n_expected_in++;
    if (item.cmd == sjfs_pkg::CMD_ARRIVE) n_arrivals++;
    else n_ticks++;
  endtask

  task automatic await_all_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_expected_in != n_expected_out);
  endtask

  task automatic write_mode(input bit value);
    await_all_reports();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    srtf_mode = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_ticks();
    offer_item(make_tick());
    offer_item(make_arrival(8'd0, 16'd0));
    offer_item(make_tick());
  endtask

  task automatic test_single_job();
    offer_item(make_arrival(8'd7, 16'd2));
    offer_item(make_tick());
    offer_item(make_tick());
  endtask

  task automatic test_ties();
    offer_item(make_arrival(8'd10, 16'd3));
    offer_item(make_arrival(8'd20, 16'd3));
    offer_item(make_arrival(8'd20, 16'd3));
    offer_item(make_tick());
    offer_item(make_tick());
  endtask

  task automatic test_mode_switch();
    write_mode(1'b0);
    offer_item(make_arrival(8'd30, 16'd1));
    offer_item(make_tick());
    offer_item(make_tick());
    offer_item(make_tick());
    write_mode(1'b1);
    offer_item(make_arrival(8'd50, 16'd1));
    offer_item(make_tick());
  endtask

  task automatic test_table_full();
    int free;
    forever begin
      free = 0;
      foreach (slot_busy[i]) if (!slot_busy[i]) free++;
      if (free == 0) break;
      offer_item(make_arrival(8'($urandom), 16'($urandom_range(1, 4))));
    end
    offer_item(make_arrival(8'd99, 16'd1));
    offer_item(make_arrival(8'd98, 16'd0));
  endtask

  task automatic test_random_phases();
    for (int mode = 1; mode >= 0; mode--) begin
      for (int phase = 0; phase < 4; phase++) begin
        write_mode(mode[0]);
        case (phase)
          0: begin
            send_gap_pct = 0;
            recv_stall_pct <= 0;
          end
          1: begin
            send_gap_pct = 72;
            recv_stall_pct <= 0;
          end
          2: begin
            send_gap_pct = 0;
            recv_stall_pct <= 72;
          end
          default: begin
            send_gap_pct = 32;
            recv_stall_pct <= 32;
          end
        endcase
        repeat (PHASE_ITEMS) offer_item(random_item());
      end
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct <= 0;
    hold_request <= 1'b1;
    repeat (24) offer_item(random_item());
    await_all_reports();
  endtask

  task automatic test_wide_fields();
    write_mode(1'b1);
    offer_item(make_arrival(8'hFF, 16'hFFFF));
    offer_item(make_arrival(8'h00, 16'h0001));
    offer_item(make_tick());
    offer_item(make_tick());
    offer_item(make_tick());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_single_job();
    test_ties();
    test_mode_switch();
    test_table_full();
    test_random_phases();
    test_backpressure();
    test_wide_fields();
    await_all_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d arrivals and %0d ticks in both scheduling modes under varied flow control.",
             n_arrivals, n_ticks);
    $display("Saw %0d finished jobs, %0d rejected arrivals and %0d idle ticks.",
             n_finished, n_rejected, n_idle);
    if (errors == 0) begin
      $display("shortest_job_first_scheduler: match");
    end else begin
      $display("shortest_job_first_scheduler: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout with %0d results outstanding", $time,
             n_expected_in - n_expected_out);
    $display("shortest_job_first_scheduler: mismatch");
    $finish;
  end

endmodule
